// ===== hdl/vcc_pkg.sv =====
package vcc_pkg;

    localparam int PRICE_REGS            = 6;
    localparam int FACE_COUNT            = 5;
    localparam int DEF_NUM_PRODUCTS      = 6;
    localparam int DEF_NUM_DENOMINATIONS = 5;

    localparam int CMD_W    = 3;
    localparam int COIN_W   = 11;
    localparam int SLOT_W   = 3;
    localparam int COUNT_W  = 16;
    localparam int STATUS_W = 4;
    localparam int CREDIT_W = 11;
    localparam int DEN_W    = 10;
    localparam int QTY_W    = 8;
    localparam int STOCK_W  = 8;
    localparam int CFG_IDX_W = 3;

    // q = (rest * recip) >> RECIP_SHIFT is exact for rest < 2**CREDIT_W
    localparam int RECIP_SHIFT = 21;
    localparam int RECIP_W     = 18;
    localparam int PROD_W      = CREDIT_W + RECIP_W;

    localparam logic [CREDIT_W-1:0] PRICE_RESET = 11'd100;
    localparam logic [CREDIT_W-1:0] LIMIT_RESET = 11'd1990;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT  = 3'd6;

    localparam logic [CMD_W-1:0] CMD_INSERT  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_SELECT  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_CHANGE  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_RESTOCK = 3'd3;
    localparam logic [CMD_W-1:0] CMD_LOAD    = 3'd4;

    localparam logic [STATUS_W-1:0] ST_ACCEPTED = 4'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_COIN = 4'd1;
    localparam logic [STATUS_W-1:0] ST_OVER     = 4'd2;
    localparam logic [STATUS_W-1:0] ST_BOUGHT   = 4'd3;
    localparam logic [STATUS_W-1:0] ST_BAD_NUM  = 4'd4;
    localparam logic [STATUS_W-1:0] ST_SHORT    = 4'd5;
    localparam logic [STATUS_W-1:0] ST_SOLD_OUT = 4'd6;
    localparam logic [STATUS_W-1:0] ST_NOTHING  = 4'd7;
    localparam logic [STATUS_W-1:0] ST_COINS    = 4'd8;
    localparam logic [STATUS_W-1:0] ST_DONE     = 4'd9;
    localparam logic [STATUS_W-1:0] ST_LOADED   = 4'd10;

    typedef enum logic [5:0] {
        S_IDLE     = 6'b000001,
        S_EXEC     = 6'b000010,
        S_CHG_MUL  = 6'b000100,
        S_CHG_QUO  = 6'b001000,
        S_CHG_PAY  = 6'b010000,
        S_CHG_DONE = 6'b100000
    } t_state;

    function automatic logic [DEN_W-1:0] face_of(input logic [2:0] idx);
        logic [DEN_W-1:0] f;
        case (idx)
            3'd0:    f = 10'd10;
            3'd1:    f = 10'd50;
            3'd2:    f = 10'd100;
            3'd3:    f = 10'd500;
            3'd4:    f = 10'd1000;
            default: f = '0;
        endcase
        return f;
    endfunction

    function automatic logic [RECIP_W-1:0] recip_of(input logic [2:0] idx);
        logic [RECIP_W-1:0] r;
        case (idx)
            3'd0:    r = 18'd209716;
            3'd1:    r = 18'd41944;
            3'd2:    r = 18'd20972;
            3'd3:    r = 18'd4195;
            3'd4:    r = 18'd2098;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// ===== hdl/vcc_mul.sv =====
module vcc_mul #(
    parameter int A_W = 11,
    parameter int B_W = 18
) (
    input  logic               i_clk,
    input  logic [A_W-1:0]     i_a,
    input  logic [B_W-1:0]     i_b,
    output logic [A_W+B_W-1:0] o_p
);

    logic [A_W+B_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= (A_W+B_W)'(i_a) * (A_W+B_W)'(i_b);
    end

    assign o_p = r_p;

endmodule

// ===== hdl/vending_credit_and_change_controller_core.sv =====
// Vending credit and change controller.
// Input channel (i_in_valid / o_in_ready) carries one command word: insert
// coin, select product, return change, restock or load coins. Output channel
// (o_out_valid / i_out_ready) returns result words; o_last marks the final
// word of a command. Prices and the credit limit are set through the plain
// write port (i_cfg_we, i_cfg_idx, i_cfg_data); the user must write them
// only while the block is idle, which the block itself does not enforce.
// Timing: a command is taken, executed in the next cycle and its result
// word is registered at the end of that execute cycle. The block takes one
// command at a time and is ready again once its last result word has left
// the output register. Change return runs the shared multiplier in three
// steps per denomination (quotient by reciprocal, quotient times face value,
// pay); the pay step waits while the output register is stalled.
// A stalled receiver holds the output register; the sequencer waits on it.
// Reset (synchronous, active low) clears credit, stock and coin counts,
// sets all prices to 100 and the credit limit to 1990, and empties the
// output register. No clearing pass is needed.
module vending_credit_and_change_controller_core #(
    parameter int NUM_PRODUCTS      = vcc_pkg::DEF_NUM_PRODUCTS,
    parameter int NUM_DENOMINATIONS = vcc_pkg::DEF_NUM_DENOMINATIONS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [vcc_pkg::CMD_W-1:0]      i_command,
    input  logic [vcc_pkg::COIN_W-1:0]     i_coin_value,
    input  logic [vcc_pkg::SLOT_W-1:0]     i_slot,
    input  logic [vcc_pkg::COUNT_W-1:0]    i_count,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [vcc_pkg::STATUS_W-1:0]   o_status,
    output logic [vcc_pkg::CREDIT_W-1:0]   o_credit_after,
    output logic [vcc_pkg::DEN_W-1:0]      o_denomination,
    output logic [vcc_pkg::QTY_W-1:0]      o_coin_quantity,
    output logic [vcc_pkg::CREDIT_W-1:0]   o_undispensed,
    output logic                           o_last,
    input  logic                           i_cfg_we,
    input  logic [vcc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [vcc_pkg::CREDIT_W-1:0]   i_cfg_data
);

    import vcc_pkg::*;

    localparam int PROD_CNT  = (NUM_PRODUCTS < PRICE_REGS) ? NUM_PRODUCTS : PRICE_REGS;
    localparam int DENOM_CNT = (NUM_DENOMINATIONS < FACE_COUNT) ? NUM_DENOMINATIONS : FACE_COUNT;
    localparam int PIDX_W    = (PROD_CNT > 1) ? $clog2(PROD_CNT) : 1;
    localparam int DIDX_W    = (DENOM_CNT > 1) ? $clog2(DENOM_CNT) : 1;

    t_state                 r_state, n_state;
    logic [CMD_W-1:0]       r_cmd;
    logic [COIN_W-1:0]      r_coin;
    logic [SLOT_W-1:0]      r_slot;
    logic [COUNT_W-1:0]     r_cnt;
    logic [CREDIT_W-1:0]    r_credit, n_credit;
    logic [CREDIT_W-1:0]    r_limit;
    logic [CREDIT_W-1:0]    r_price [PRICE_REGS];
    logic [STOCK_W-1:0]     r_stock [PROD_CNT];
    logic [STOCK_W-1:0]     n_stock [PROD_CNT];
    logic [COUNT_W-1:0]     r_coins [DENOM_CNT];
    logic [COUNT_W-1:0]     n_coins [DENOM_CNT];
    logic [CREDIT_W-1:0]    r_rest, n_rest;
    logic [DIDX_W-1:0]      r_den, n_den;
    logic [QTY_W-1:0]       r_quo, n_quo;

    logic                   r_out_valid, n_out_valid;
    logic [STATUS_W-1:0]    r_status, n_status;
    logic [CREDIT_W-1:0]    r_out_credit, n_out_credit;
    logic [DEN_W-1:0]       r_out_den, n_out_den;
    logic [QTY_W-1:0]       r_out_qty, n_out_qty;
    logic [CREDIT_W-1:0]    r_out_und, n_out_und;
    logic                   r_out_last, n_out_last;

    logic [CREDIT_W-1:0]    mul_a;
    logic [RECIP_W-1:0]     mul_b;
    logic [PROD_W-1:0]      mul_p;

    logic                   in_fire;
    logic                   out_free;
    logic                   coin_hit;
    logic [DIDX_W-1:0]      coin_idx;
    logic [CREDIT_W:0]      coin_sum;
    logic                   prod_ok;
    logic                   den_ok;
    logic [PIDX_W-1:0]      pidx;
    logic [DIDX_W-1:0]      lidx;
    logic [CREDIT_W-1:0]    price_sel;
    logic [COUNT_W-1:0]     coin_cur;
    logic                   pay_ok;
    logic                   step;

    assign o_in_ready = (r_state == S_IDLE) && !r_out_valid;
    assign in_fire    = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;

    assign coin_sum  = {1'b0, r_credit} + {1'b0, r_coin};
    assign prod_ok   = (r_slot != '0) && (32'(r_slot) <= PROD_CNT);
    assign den_ok    = 32'(r_slot) < DENOM_CNT;
    assign pidx      = PIDX_W'(r_slot - 3'd1);
    assign lidx      = DIDX_W'(r_slot);
    assign price_sel = r_price[3'(r_slot - 3'd1)];
    assign coin_cur  = r_coins[r_den];
    assign pay_ok    = (r_quo != '0) && (coin_cur >= COUNT_W'(r_quo));

    always_comb begin
        coin_hit = 1'b0;
        coin_idx = '0;
        for (int i = 0; i < DENOM_CNT; i++) begin
            if ({1'b0, face_of(3'(i))} == r_coin) begin
                coin_hit = 1'b1;
                coin_idx = DIDX_W'(i);
            end
        end
    end

    // while paying, the held quotient keeps the product steady across stalls
    always_comb begin
        if (r_state == S_CHG_MUL) begin
            mul_a = r_rest;
            mul_b = recip_of(3'(r_den));
        end else begin
            mul_a = (r_state == S_CHG_QUO) ? CREDIT_W'(mul_p[RECIP_SHIFT +: QTY_W])
                                           : CREDIT_W'(r_quo);
            mul_b = RECIP_W'(face_of(3'(r_den)));
        end
    end

    vcc_mul #(
        .A_W (CREDIT_W),
        .B_W (RECIP_W)
    ) u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    always_comb begin
        n_state      = r_state;
        n_credit     = r_credit;
        n_stock      = r_stock;
        n_coins      = r_coins;
        n_rest       = r_rest;
        n_den        = r_den;
        n_quo        = r_quo;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_status     = r_status;
        n_out_credit = r_out_credit;
        n_out_den    = r_out_den;
        n_out_qty    = r_out_qty;
        n_out_und    = r_out_und;
        n_out_last   = r_out_last;
        step         = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state    = S_IDLE;
                n_out_den  = '0;
                n_out_qty  = '0;
                n_out_und  = '0;
                n_out_last = 1'b1;
                case (r_cmd)
                    CMD_INSERT: begin
                        n_out_valid = 1'b1;
                        if (!coin_hit) begin
                            n_status = ST_BAD_COIN;
                        end else if (coin_sum > {1'b0, r_limit}) begin
                            n_status = ST_OVER;
                        end else begin
                            n_status = ST_ACCEPTED;
                            n_credit = coin_sum[CREDIT_W-1:0];
                            if (r_coins[coin_idx] != '1) begin
                                n_coins[coin_idx] = r_coins[coin_idx] + COUNT_W'(1);
                            end
                        end
                    end
                    CMD_SELECT: begin
                        n_out_valid = 1'b1;
                        if (!prod_ok) begin
                            n_status = ST_BAD_NUM;
                        end else if (r_credit < price_sel) begin
                            n_status = ST_SHORT;
                        end else if (r_stock[pidx] == '0) begin
                            n_status = ST_SOLD_OUT;
                        end else begin
                            n_status       = ST_BOUGHT;
                            n_credit       = r_credit - price_sel;
                            n_stock[pidx]  = r_stock[pidx] - STOCK_W'(1);
                        end
                    end
                    CMD_CHANGE: begin
                        if (r_credit == '0) begin
                            n_out_valid = 1'b1;
                            n_status    = ST_NOTHING;
                        end else begin
                            n_rest  = r_credit;
                            n_den   = DIDX_W'(DENOM_CNT - 1);
                            n_state = S_CHG_MUL;
                        end
                    end
                    CMD_RESTOCK: begin
                        n_out_valid = 1'b1;
                        if (!prod_ok) begin
                            n_status = ST_BAD_NUM;
                        end else begin
                            n_status      = ST_LOADED;
                            n_stock[pidx] = (r_cnt > COUNT_W'(255)) ? '1 : r_cnt[STOCK_W-1:0];
                        end
                    end
                    CMD_LOAD: begin
                        n_out_valid = 1'b1;
                        if (!den_ok) begin
                            n_status = ST_BAD_NUM;
                        end else begin
                            n_status      = ST_LOADED;
                            n_coins[lidx] = r_cnt;
                        end
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
                n_out_credit = n_credit;
            end
            S_CHG_MUL: begin
                n_state = S_CHG_QUO;
            end
            S_CHG_QUO: begin
                n_quo   = mul_p[RECIP_SHIFT +: QTY_W];
                n_state = S_CHG_PAY;
            end
            S_CHG_PAY: begin
                if (!pay_ok) begin
                    step = 1'b1;
                end else if (out_free) begin
                    step          = 1'b1;
                    n_out_valid   = 1'b1;
                    n_status      = ST_COINS;
                    n_out_credit  = '0;
                    n_out_den     = face_of(3'(r_den));
                    n_out_qty     = r_quo;
                    n_out_und     = '0;
                    n_out_last    = 1'b0;
                    n_coins[r_den] = coin_cur - COUNT_W'(r_quo);
                    n_rest        = r_rest - mul_p[CREDIT_W-1:0];
                end
                if (step) begin
                    if (r_den == '0) begin
                        n_state = S_CHG_DONE;
                    end else begin
                        n_den   = r_den - DIDX_W'(1);
                        n_state = S_CHG_MUL;
                    end
                end
            end
            S_CHG_DONE: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_status     = ST_DONE;
                    n_out_credit = '0;
                    n_out_den    = '0;
                    n_out_qty    = '0;
                    n_out_und    = r_rest;
                    n_out_last   = 1'b1;
                    n_credit     = '0;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_credit    <= '0;
            r_stock     <= '{default: '0};
            r_coins     <= '{default: '0};
            r_price     <= '{default: PRICE_RESET};
            r_limit     <= LIMIT_RESET;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_credit    <= n_credit;
            r_stock     <= n_stock;
            r_coins     <= n_coins;
            if (i_cfg_we) begin
                if (32'(i_cfg_idx) < PRICE_REGS) begin
                    r_price[i_cfg_idx] <= i_cfg_data;
                end else if (i_cfg_idx == CFG_LIMIT) begin
                    r_limit <= i_cfg_data;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_cmd  <= i_command;
            r_coin <= i_coin_value;
            r_slot <= i_slot;
            r_cnt  <= i_count;
        end
        r_rest       <= n_rest;
        r_den        <= n_den;
        r_quo        <= n_quo;
        r_status     <= n_status;
        r_out_credit <= n_out_credit;
        r_out_den    <= n_out_den;
        r_out_qty    <= n_out_qty;
        r_out_und    <= n_out_und;
        r_out_last   <= n_out_last;
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_status;
    assign o_credit_after  = r_out_credit;
    assign o_denomination  = r_out_den;
    assign o_coin_quantity = r_out_qty;
    assign o_undispensed   = r_out_und;
    assign o_last          = r_out_last;

endmodule

// ===== hdl/vcc_checker.sv =====
module vcc_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           o_in_ready,
    input  logic                           o_out_valid,
    input  logic                           i_out_ready,
    input  logic [vcc_pkg::STATUS_W-1:0]   o_status,
    input  logic [vcc_pkg::CREDIT_W-1:0]   o_credit_after,
    input  logic [vcc_pkg::QTY_W-1:0]      o_coin_quantity,
    input  logic                           o_last
);

    import vcc_pkg::*;

    // one command in flight: no new word while a result waits
    a_ready_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !o_out_valid)
        else $error("ready while result pending");

    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("ready right after taking a word");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_status) && $stable(o_last)
             && $stable(o_coin_quantity)))
        else $error("stalled result changed");

    a_mid_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_last) |->
            (o_status == ST_COINS && o_credit_after == '0 && o_coin_quantity != '0))
        else $error("non-final word is not a coin payout");

    a_done_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == ST_DONE || o_status == ST_NOTHING)) |->
            (o_credit_after == '0 && o_last))
        else $error("change finish leaves credit");

endmodule

bind vending_credit_and_change_controller_core vcc_checker u_vcc_checker (.*);
